FILE: rtl/core/utf8_aware_string_splitter_assert.svh
// Assertion macros used by the checker file of the string splitter.
`ifndef UTF8_AWARE_STRING_SPLITTER_ASSERT_SVH
`define UTF8_AWARE_STRING_SPLITTER_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define UASS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define UASS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/uass_pkg.sv
// Shared types, constants and UTF-8 helpers of the string splitter.
`default_nettype none

package uass_pkg;

    localparam int SEP_REG_BYTES = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int CP_W          = 21;
    localparam int SLEN_W        = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEP_MODE      = 2'd0,
        CFG_SEP_CODEPOINT = 2'd1,
        CFG_SEP_BYTES     = 2'd2,
        CFG_SEP_LENGTH    = 2'd3
    } t_cfg_idx;

    // UTF-8 tags and masks
    localparam logic [7:0] UTF_CONT_TAG = 8'h80;
    localparam logic [7:0] LEAD2_TAG    = 8'hC0;
    localparam logic [7:0] LEAD3_TAG    = 8'hE0;
    localparam logic [7:0] LEAD4_TAG    = 8'hF0;
    localparam logic [7:0] LEAD2_MASK   = 8'hE0;
    localparam logic [7:0] LEAD3_MASK   = 8'hF0;
    localparam logic [7:0] LEAD4_MASK   = 8'hF8;

    localparam logic [CP_W-1:0] CP_LIM1 = 21'h00080;
    localparam logic [CP_W-1:0] CP_LIM2 = 21'h00800;
    localparam logic [CP_W-1:0] CP_LIM3 = 21'h10000;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_SHIFT = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       piece_end;
        logic       string_done;
        logic       last;
    } t_result;

    // Length of the character that a lead byte opens; 0 for a byte that cannot lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        if (b < UTF_CONT_TAG) begin
            n = 3'd1;
        end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            n = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            n = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/uass_if.sv
// Valid/ready stream interfaces for the input bytes and the result items.
`default_nettype none

interface uass_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_end;

    modport source (output valid, output data_byte, output is_end, input ready);
    modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

interface uass_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       piece_end;
    logic       string_done;
    logic       last;

    modport source (output valid, output out_byte, output has_byte, output piece_end,
                    output string_done, output last, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input piece_end,
                    input string_done, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/uass_cell.sv
// One window cell: holds a byte, shifts toward the head, compares with its separator byte.
`default_nettype none

module uass_cell (
    input  wire logic              i_clk,
    input  wire uass_pkg::t_cell_op i_op,
    input  wire logic [7:0]        i_in,
    input  wire logic [7:0]        i_next,
    input  wire logic [7:0]        i_sep,
    input  wire logic              i_held,
    input  wire logic              i_at,
    output logic [7:0]             o_byte,
    output logic                   o_eq
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        case (i_op)
            uass_pkg::CELL_LOAD:  n_byte = i_in;
            uass_pkg::CELL_SHIFT: n_byte = i_next;
            default:              n_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    // A held byte compares itself; the slot just past the held bytes compares the new byte.
    assign o_eq   = i_held ? (r_byte == i_sep) : (i_at ? (i_in == i_sep) : 1'b1);
    assign o_byte = r_byte;

endmodule

`default_nettype wire

FILE: rtl/core/uass_sep_enc.sv
// Separator builder: byte string register or UTF-8 encoding of the separator character.
`default_nettype none

module uass_sep_enc #(
    parameter int LMAX = 8
) (
    input  wire logic                          i_mode,
    input  wire logic [uass_pkg::CP_W-1:0]     i_cp,
    input  wire logic [uass_pkg::CFG_DATA_W-1:0] i_bytes,
    input  wire logic [uass_pkg::SLEN_W-1:0]   i_slen,
    output logic [LMAX-1:0][7:0]               o_sep,
    output logic [uass_pkg::SLEN_W-1:0]        o_len
);

    always_comb begin
        o_sep = '0;
        o_len = '0;
        if (i_mode) begin
            if (i_cp < uass_pkg::CP_LIM1) begin
                o_sep[0] = i_cp[7:0];
                o_len    = 4'd1;
            end else if (i_cp < uass_pkg::CP_LIM2) begin
                o_sep[0] = uass_pkg::LEAD2_TAG | {3'b000, i_cp[10:6]};
                o_sep[1] = uass_pkg::UTF_CONT_TAG | {2'b00, i_cp[5:0]};
                o_len    = 4'd2;
            end else if (i_cp < uass_pkg::CP_LIM3) begin
                o_sep[0] = uass_pkg::LEAD3_TAG | {4'b0000, i_cp[15:12]};
                o_sep[1] = uass_pkg::UTF_CONT_TAG | {2'b00, i_cp[11:6]};
                o_sep[2] = uass_pkg::UTF_CONT_TAG | {2'b00, i_cp[5:0]};
                o_len    = 4'd3;
            end else begin
                // codepoints above the Unicode range keep the same bit layout
                o_sep[0] = uass_pkg::LEAD4_TAG | {5'b00000, i_cp[20:18]};
                o_sep[1] = uass_pkg::UTF_CONT_TAG | {2'b00, i_cp[17:12]};
                o_sep[2] = uass_pkg::UTF_CONT_TAG | {2'b00, i_cp[11:6]};
                o_sep[3] = uass_pkg::UTF_CONT_TAG | {2'b00, i_cp[5:0]};
                o_len    = 4'd4;
            end
        end else begin
            o_len = (i_slen > uass_pkg::SLEN_W'(LMAX)) ? uass_pkg::SLEN_W'(LMAX) : i_slen;
            for (int j = 0; j < LMAX; j++) begin
                o_sep[j] = i_bytes[8*j +: 8];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/uass_out_q.sv
// Two-entry result queue that decouples the window from the output handshake.
`default_nettype none

module uass_out_q (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire uass_pkg::t_result i_push_data,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output uass_pkg::t_result      o_data
);

    uass_pkg::t_result r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/utf8_aware_string_splitter.sv
// Top level of the UTF-8 aware string splitter.
`default_nettype none

// The splitter takes a string one byte per transaction on i_in, closed by a
// transaction with is_end set, and returns the same bytes on o_out grouped
// into pieces. With a separator (a byte string of up to min(SEP_MAX, 8)
// bytes, or a character that the block UTF-8 encodes) it cuts at leftmost,
// non-overlapping matches; a match closes the piece with a byteless result,
// so back-to-back separators give empty pieces, and the end marker flushes
// the held bytes and closes the string. With a zero separator length every
// UTF-8 character becomes a piece; bad lead bytes and characters cut short
// by the end come out as single bytes. Held bytes live in a row of
// min(SEP_MAX, 8) - 1 window cells that shift toward the head cell; the
// separator compare runs across all cells in parallel. A plain byte leaves
// the block in ST_RUN. After a completed multi-byte character the head
// cell sends the rest of it, one byte a cycle while the queue is not full;
// an end marker sends every held byte, plus the closing result in separator
// mode; with nothing held it only closes the string. Results go through a
// two-entry queue, so i_in.ready never waits on o_out.ready in the same
// cycle; it drops only while reset is held, while the head cell drains a
// character or a flush, or while the queue is full. Write the configuration
// only while the block is idle; any write, even of the same value, drops the
// held bytes. Reset is synchronous and needs no clearing pass.
module utf8_aware_string_splitter #(
    parameter int SEP_MAX = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    uass_in_if.sink                              i_in,
    uass_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [uass_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [uass_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Longest separator, cells in the window, and the fill counter width.
    localparam int LMAX = (SEP_MAX < uass_pkg::SEP_REG_BYTES) ? SEP_MAX
                                                              : uass_pkg::SEP_REG_BYTES;
    localparam int NC   = LMAX - 1;
    localparam int CW   = $clog2(LMAX);

    // Drain sequencer: one-hot.
    typedef enum logic [3:0] {
        ST_RUN      = 4'b0001,   // take input bytes
        ST_SEP_END  = 4'b0010,   // flush window after end marker, then close string
        ST_CHR_DONE = 4'b0100,   // send rest of a completed character
        ST_CHR_END  = 4'b1000    // re-split held bytes after end marker
    } t_state;

    // Configuration registers
    logic                            r_mode;
    logic [uass_pkg::CP_W-1:0]       r_cp;
    logic [uass_pkg::CFG_DATA_W-1:0] r_bytes;
    logic [uass_pkg::SLEN_W-1:0]     r_slen;

    // Control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_need,  n_need;
    logic [1:0]    r_run,   n_run;

    // Separator
    logic [LMAX-1:0][7:0]        sep;
    logic [uass_pkg::SLEN_W-1:0] sep_len;

    // Window cells
    uass_pkg::t_cell_op cell_op   [NC];
    logic [7:0]         cell_byte [NC];
    logic [7:0]         cell_next [NC];
    logic [NC-1:0]      cell_eq;
    logic               last_eq;
    logic               match;

    // Datapath helpers
    logic              acc;
    logic              q_full;
    logic              emit;
    uass_pkg::t_result emit_res;
    uass_pkg::t_result q_data;
    logic [7:0]        b;
    logic [7:0]        head;
    logic [2:0]        lead_b;
    logic [2:0]        lead_h;
    logic [2:0]        step_n;
    logic              at_last;
    logic              fin;

    function automatic uass_pkg::t_result mk_res(input logic [7:0] byte_v, input logic has,
                                                 input logic pe, input logic done,
                                                 input logic lst);
        uass_pkg::t_result r;
        r.out_byte    = has ? byte_v : 8'h00;
        r.has_byte    = has;
        r.piece_end   = pe;
        r.string_done = done;
        r.last        = lst;
        return r;
    endfunction

    //------------------------------------------------------------------
    // Configuration port
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_cp    <= '0;
            r_bytes <= '0;
            r_slen  <= '0;
        end else if (i_cfg_we) begin
            case (uass_pkg::t_cfg_idx'(i_cfg_idx))
                uass_pkg::CFG_SEP_MODE:      r_mode  <= i_cfg_data[0];
                uass_pkg::CFG_SEP_CODEPOINT: r_cp    <= i_cfg_data[uass_pkg::CP_W-1:0];
                uass_pkg::CFG_SEP_BYTES:     r_bytes <= i_cfg_data;
                uass_pkg::CFG_SEP_LENGTH:    r_slen  <= i_cfg_data[uass_pkg::SLEN_W-1:0];
                default:                     r_mode  <= r_mode;
            endcase
        end
    end

    uass_sep_enc #(
        .LMAX (LMAX)
    ) u_sep_enc (
        .i_mode  (r_mode),
        .i_cp    (r_cp),
        .i_bytes (r_bytes),
        .i_slen  (r_slen),
        .o_sep   (sep),
        .o_len   (sep_len)
    );

    //------------------------------------------------------------------
    // Window cell row; each cell shifts from its neighbor above, the top
    // cell takes the incoming byte.
    //------------------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < NC; g++) begin : g_cell
            if (g == NC - 1) begin : g_top
                assign cell_next[g] = b;
            end else begin : g_mid
                assign cell_next[g] = cell_byte[g+1];
            end

            uass_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (cell_op[g]),
                .i_in   (b),
                .i_next (cell_next[g]),
                .i_sep  (sep[g]),
                .i_held (CW'(g) < r_count),
                .i_at   (CW'(g) == r_count),
                .o_byte (cell_byte[g]),
                .o_eq   (cell_eq[g])
            );
        end
    endgenerate

    // The last separator position has no cell: only the new byte lands there.
    assign last_eq = (r_count == CW'(NC)) ? (b == sep[NC]) : 1'b1;
    assign match   = (&cell_eq) && last_eq;

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    assign b       = i_in.data_byte;
    assign head    = cell_byte[0];
    assign acc     = i_in.valid && i_in.ready;
    assign lead_b  = uass_pkg::lead_len(b);
    assign lead_h  = uass_pkg::lead_len(head);
    assign at_last = ((uass_pkg::SLEN_W'(r_count) + 4'd1) == sep_len);
    assign fin     = (r_count == CW'(1));

    // Piece length at the head while re-splitting; a lead that does not fit goes alone.
    always_comb begin
        if (r_run != 2'd0) begin
            step_n = {1'b0, r_run};
        end else if (lead_h == 3'd0 || 4'(lead_h) > 4'(r_count)) begin
            step_n = 3'd1;
        end else begin
            step_n = lead_h;
        end
    end

    // Hold off input while reset is asserted, while draining, or while the queue is full.
    assign i_in.ready = i_rst_n && (r_state == ST_RUN) && !q_full;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_need   = r_need;
        n_run    = r_run;
        emit     = 1'b0;
        emit_res = mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        for (int j = 0; j < NC; j++) begin
            cell_op[j] = uass_pkg::CELL_HOLD;
        end

        case (r_state)
            ST_RUN: begin
                if (acc) begin
                    if (i_in.is_end) begin
                        n_need = 2'd0;
                        if (r_count == '0) begin
                            // nothing held: close the string at once
                            emit     = 1'b1;
                            emit_res = mk_res(8'h00, 1'b0, (sep_len != '0), 1'b1, 1'b1);
                        end else if (sep_len != '0) begin
                            emit     = 1'b1;
                            emit_res = mk_res(head, 1'b1, 1'b0, 1'b0, 1'b0);
                            for (int j = 0; j < NC; j++) begin
                                cell_op[j] = uass_pkg::CELL_SHIFT;
                            end
                            n_count = r_count - CW'(1);
                            n_state = ST_SEP_END;
                        end else begin
                            emit     = 1'b1;
                            emit_res = mk_res(head, 1'b1, (step_n == 3'd1), fin, fin);
                            for (int j = 0; j < NC; j++) begin
                                cell_op[j] = uass_pkg::CELL_SHIFT;
                            end
                            n_run   = 2'(step_n - 3'd1);
                            n_count = r_count - CW'(1);
                            n_state = fin ? ST_RUN : ST_CHR_END;
                        end
                    end else if (sep_len != '0) begin
                        if (!at_last) begin
                            // window not yet separator-long: append
                            for (int j = 0; j < NC; j++) begin
                                if (CW'(j) == r_count) begin
                                    cell_op[j] = uass_pkg::CELL_LOAD;
                                end
                            end
                            n_count = r_count + CW'(1);
                        end else if (match) begin
                            emit     = 1'b1;
                            emit_res = mk_res(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
                            n_count  = '0;
                        end else begin
                            // no match: release the oldest byte, slide the window
                            emit     = 1'b1;
                            emit_res = mk_res((r_count == '0) ? b : head, 1'b1, 1'b0, 1'b0,
                                              1'b1);
                            for (int j = 0; j < NC; j++) begin
                                cell_op[j] = (CW'(j + 1) == r_count) ? uass_pkg::CELL_LOAD
                                                                     : uass_pkg::CELL_SHIFT;
                            end
                        end
                    end else if (r_count == '0) begin
                        if (lead_b <= 3'd1) begin
                            emit     = 1'b1;
                            emit_res = mk_res(b, 1'b1, 1'b1, 1'b0, 1'b1);
                        end else begin
                            cell_op[0] = uass_pkg::CELL_LOAD;
                            n_count    = CW'(1);
                            n_need     = 2'(lead_b - 3'd1);
                        end
                    end else if (r_need == 2'd1) begin
                        // character complete: send the head now, rest from ST_CHR_DONE
                        emit     = 1'b1;
                        emit_res = mk_res(head, 1'b1, 1'b0, 1'b0, 1'b0);
                        for (int j = 0; j < NC; j++) begin
                            cell_op[j] = (CW'(j + 1) == r_count) ? uass_pkg::CELL_LOAD
                                                                 : uass_pkg::CELL_SHIFT;
                        end
                        n_need  = 2'd0;
                        n_state = ST_CHR_DONE;
                    end else begin
                        for (int j = 0; j < NC; j++) begin
                            if (CW'(j) == r_count) begin
                                cell_op[j] = uass_pkg::CELL_LOAD;
                            end
                        end
                        n_count = r_count + CW'(1);
                        n_need  = r_need - 2'd1;
                    end
                end
            end

            ST_SEP_END: begin
                if (!q_full) begin
                    emit = 1'b1;
                    if (r_count != '0) begin
                        emit_res = mk_res(head, 1'b1, 1'b0, 1'b0, 1'b0);
                        for (int j = 0; j < NC; j++) begin
                            cell_op[j] = uass_pkg::CELL_SHIFT;
                        end
                        n_count = r_count - CW'(1);
                    end else begin
                        emit_res = mk_res(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
                        n_state  = ST_RUN;
                    end
                end
            end

            ST_CHR_DONE: begin
                if (!q_full) begin
                    emit     = 1'b1;
                    emit_res = mk_res(head, 1'b1, fin, 1'b0, fin);
                    for (int j = 0; j < NC; j++) begin
                        cell_op[j] = uass_pkg::CELL_SHIFT;
                    end
                    n_count = r_count - CW'(1);
                    if (fin) begin
                        n_state = ST_RUN;
                    end
                end
            end

            ST_CHR_END: begin
                if (!q_full) begin
                    emit     = 1'b1;
                    emit_res = mk_res(head, 1'b1, (step_n == 3'd1), fin, fin);
                    for (int j = 0; j < NC; j++) begin
                        cell_op[j] = uass_pkg::CELL_SHIFT;
                    end
                    n_run   = 2'(step_n - 3'd1);
                    n_count = r_count - CW'(1);
                    if (fin) begin
                        n_state = ST_RUN;
                    end
                end
            end

            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_count <= '0;
            r_need  <= 2'd0;
            r_run   <= 2'd0;
        end else if (i_cfg_we) begin
            // any register write drops the held bytes
            r_state <= ST_RUN;
            r_count <= '0;
            r_need  <= 2'd0;
            r_run   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_need  <= n_need;
            r_run   <= n_run;
        end
    end

    //------------------------------------------------------------------
    // Result queue
    //------------------------------------------------------------------
    uass_out_q u_out_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (emit),
        .i_push_data (emit_res),
        .o_full      (q_full),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_data      (q_data)
    );

    assign o_out.out_byte    = q_data.out_byte;
    assign o_out.has_byte    = q_data.has_byte;
    assign o_out.piece_end   = q_data.piece_end;
    assign o_out.string_done = q_data.string_done;
    assign o_out.last        = q_data.last;

endmodule

`default_nettype wire

FILE: rtl/core/uass_checker.sv
// Port-level checks of the string splitter and their bind to the top level.
`default_nettype none

`include "utf8_aware_string_splitter_assert.svh"

module uass_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_has_byte,
    input  wire logic       i_piece_end,
    input  wire logic       i_string_done,
    input  wire logic       i_last
);

    // Hold a stalled result.
    `UASS_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_string_done) && $stable(i_last), "stalled result changed")

    // The closing result of a string is always the last one of its transaction.
    `UASS_ASSERT_CLK(a_done_last, i_clk, i_rst_n, i_out_valid && i_string_done |-> i_last, "string done without last")

    // A byteless result carries a zero byte and ends a piece or the string.
    `UASS_ASSERT_CLK(a_empty_res, i_clk, i_rst_n, i_out_valid && !i_has_byte |-> i_out_byte == 8'h00 && (i_piece_end || i_string_done), "malformed byteless result")

    // Reset empties the result queue.
    `UASS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result left after reset")

endmodule

bind utf8_aware_string_splitter uass_checker u_uass_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_has_byte    (o_out.has_byte),
    .i_piece_end   (o_out.piece_end),
    .i_string_done (o_out.string_done),
    .i_last        (o_out.last)
);

`default_nettype wire
